### hw/rtl/hash_join_int64_key_core_defines.svh
// assertion macros shared by the hash join core
`ifndef HASH_JOIN_INT64_KEY_CORE_DEFINES_SVH
`define HASH_JOIN_INT64_KEY_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define HJ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define HJ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/hj_pkg.sv
// ----------------------------------------------------------------------------
// hj_pkg
// Types and constants of the hash join core: command, join kind, result
// codes, sequencer states and the hash constants.
// ----------------------------------------------------------------------------
package hj_pkg;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_PROBE  = 2'd1,
    CMD_FINAL  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  localparam logic [2:0] JK_INNER = 3'd0;
  localparam logic [2:0] JK_LEFT  = 3'd1;
  localparam logic [2:0] JK_FULL  = 3'd2;
  localparam logic [2:0] JK_SEMI  = 3'd3;
  localparam logic [2:0] JK_ANTI  = 3'd4;

  localparam logic [1:0] RK_PAIR   = 2'd0;
  localparam logic [1:0] RK_PROBE  = 2'd1;
  localparam logic [1:0] RK_BUILD  = 2'd2;
  localparam logic [1:0] RK_REJECT = 2'd3;

  localparam logic [1:0] ERR_OK   = 2'd0;
  localparam logic [1:0] ERR_FULL = 2'd1;
  localparam logic [1:0] ERR_LATE = 2'd2;

  localparam logic [1:0] PH_BUILD = 2'd0;
  localparam logic [1:0] PH_PROBE = 2'd1;
  localparam logic [1:0] PH_FINAL = 2'd2;

  localparam logic [63:0] FnvBasis = 64'hCBF29CE484222325;
  localparam logic [63:0] NullMix  = 64'h00000000000000FF;

  typedef enum logic [1:0] {
    HS_IDLE,
    HS_MUL,
    HS_MOD
  } hash_state_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HASH,
    ST_SLOT_RD,
    ST_SLOT_CMP,
    ST_WALK_RD,
    ST_WALK_CMP,
    ST_DECIDE,
    ST_FIN,
    ST_FLUSH
  } core_state_e;

endpackage

### hw/rtl/hj_ram.sv
// ----------------------------------------------------------------------------
// hj_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module hj_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/hj_hash_unit.sv
// ----------------------------------------------------------------------------
// hj_hash_unit
// Iterative FNV-1a hash of a 64-bit key, one byte a cycle, followed by a
// remainder by the slot count, four bits a cycle.
// ----------------------------------------------------------------------------
module hj_hash_unit #(
  parameter int unsigned SLOTS = 128
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  input  logic [63:0]                            key_i,
  input  logic                                   null_i,
  output logic                                   done_o,
  output logic [63:0]                            hash_o,
  output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] slot_o
);
  import hj_pkg::*;

  localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [SW:0] SlotsVal = (SW + 1)'(SLOTS);

  hash_state_e hst_q, hst_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [63:0] h_q, h_d;
  logic [63:0] key_q, key_d;
  logic [63:0] sh_q, sh_d;
  logic [SW:0] rem_q, rem_d;
  logic        done_q, done_d;

  logic [63:0] mix;
  logic [63:0] mul;
  logic [SW:0] rem_step;

  // prime is 2^40 + 0x1b3
  assign mix = h_q ^ {56'd0, key_q[7:0]};
  assign mul = (mix << 40) + (mix << 8) + (mix << 7) + (mix << 5) + (mix << 4)
             + (mix << 1) + mix;

  always_comb begin
    rem_step = rem_q;
    for (int b = 0; b < 4; b++) begin
      rem_step = {rem_step[SW-1:0], sh_q[63 - b]};
      if (rem_step >= SlotsVal) begin
        rem_step = rem_step - SlotsVal;
      end
    end
  end

  always_comb begin
    hst_d = hst_q;
    case (hst_q)
      HS_IDLE: begin
        if (start_i) begin
          hst_d = null_i ? HS_MOD : HS_MUL;
        end
      end
      HS_MUL: begin
        if (cnt_q == 4'd7) begin
          hst_d = HS_MOD;
        end
      end
      HS_MOD: begin
        if (cnt_q == 4'd15) begin
          hst_d = HS_IDLE;
        end
      end
      default: hst_d = HS_IDLE;
    endcase
  end

  always_comb begin
    cnt_d  = cnt_q;
    h_d    = h_q;
    key_d  = key_q;
    sh_d   = sh_q;
    rem_d  = rem_q;
    done_d = 1'b0;
    case (hst_q)
      HS_IDLE: begin
        if (start_i) begin
          cnt_d = 4'd0;
          rem_d = '0;
          key_d = key_i;
          if (null_i) begin
            h_d  = FnvBasis ^ NullMix;
            sh_d = FnvBasis ^ NullMix;
          end else begin
            h_d = FnvBasis;
          end
        end
      end
      HS_MUL: begin
        h_d   = mul;
        key_d = key_q >> 8;
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd7) begin
          sh_d  = mul;
          cnt_d = 4'd0;
        end
      end
      HS_MOD: begin
        rem_d = rem_step;
        sh_d  = sh_q << 4;
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd15) begin
          done_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hst_q  <= HS_IDLE;
      done_q <= 1'b0;
    end else begin
      hst_q  <= hst_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    h_q   <= h_d;
    key_q <= key_d;
    sh_q  <= sh_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign hash_o = h_q;
  assign slot_o = rem_q[SW-1:0];

endmodule

### hw/rtl/hash_join_int64_key_core.sv
// ----------------------------------------------------------------------------
// hash_join_int64_key_core
// Hash join engine on one 64-bit key: build, probe and finalize commands.
// ----------------------------------------------------------------------------
// One command is taken at a time; in_ready_o is high only between commands.
// An insert or probe hashes the key and reduces it to a slot in the shared
// hash unit, then takes a registered RAM read and a compare for each probed
// slot in the slot table and for each chained build row; a null probe key
// skips all of that. Under a full join, finalize scans the match flags at
// one build row a cycle while the result path does not stall. Results
// leave through a one-deep hold stage and an output register, so a result
// item stalls the walk only when both are full.
// Reset clears the slot-used and match flags at once; no clearing pass.
module hash_join_int64_key_core #(
  parameter int unsigned BUILD_ROWS = 64,
  parameter int unsigned SLOTS      = 128,
  parameter int unsigned TAG_BITS   = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [63:0] key_i,
  input  logic        key_valid_i,
  input  logic [31:0] probe_tag_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  row_kind_o,
  output logic [31:0] out_tag_o,
  output logic [5:0]  build_index_o,
  output logic [1:0]  error_code_o,
  output logic        last_o
);
  import hj_pkg::*;

  `include "hash_join_int64_key_core_defines.svh"

  localparam int unsigned IW = (BUILD_ROWS > 1) ? $clog2(BUILD_ROWS) : 1;
  localparam int unsigned CW = IW + 1;
  localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned PW = SW + 1;
  localparam int unsigned RowW  = 64 + 1 + CW;
  localparam int unsigned SlotW = 64 + IW;
  localparam logic [CW-1:0] RowEnd  = CW'(BUILD_ROWS);
  localparam logic [PW-1:0] SlotCnt = PW'(SLOTS);
  localparam logic [SW-1:0] SlotTop = SW'(SLOTS - 1);
  localparam logic [31:0]   TagMask =
    (TAG_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << TAG_BITS) - 64'd1);

  core_state_e state_q, state_d;

  logic [2:0]  join_kind_q, join_kind_d;
  logic [1:0]  phase_q, phase_d;
  logic [CW-1:0] count_q, count_d;
  logic [SLOTS-1:0]      used_q, used_d;
  logic [BUILD_ROWS-1:0] matched_q, matched_d;

  cmd_e        cmd_q, cmd_d;
  logic [63:0] key_q, key_d;
  logic        kv_q, kv_d;
  logic [31:0] tag_q, tag_d;
  logic [2:0]  kind_q, kind_d;
  logic [SW-1:0] slot_q, slot_d;
  logic [PW-1:0] probes_q, probes_d;
  logic [CW-1:0] br_q, br_d;
  logic [CW-1:0] fin_q, fin_d;
  logic        found_q, found_d;

  logic        pend_valid_q, pend_valid_d;
  logic [1:0]  pend_kind_q, pend_kind_d;
  logic [31:0] pend_tag_q, pend_tag_d;
  logic [5:0]  pend_idx_q, pend_idx_d;
  logic [1:0]  pend_err_q, pend_err_d;

  logic        out_valid_q, out_valid_d;
  logic [1:0]  out_kind_q, out_kind_d;
  logic [31:0] out_tag_q, out_tag_d;
  logic [5:0]  out_idx_q, out_idx_d;
  logic [1:0]  out_err_q, out_err_d;
  logic        out_last_q, out_last_d;

  // hash unit
  logic          hash_start;
  logic          hash_done;
  logic [63:0]   hash_val;
  logic [SW-1:0] hash_slot;

  // memories
  logic             slot_we, slot_re;
  logic [SlotW-1:0] slot_wdata, slot_rdata;
  logic             row_we, row_re;
  logic [RowW-1:0]  row_wdata, row_rdata;
  logic [63:0]      slot_rhash;
  logic [IW-1:0]    slot_rhead;
  logic [63:0]      row_rkey;
  logic             row_rkv;
  logic [CW-1:0]    row_rnext;

  // result selection
  logic        prod;
  logic [1:0]  prod_kind;
  logic [31:0] prod_tag;
  logic [5:0]  prod_idx;
  logic [1:0]  prod_err;
  logic        flush_req;
  logic        out_free;
  logic        stall;

  logic is_insert;
  logic slot_miss;
  logic slot_hit;
  logic chain_end;
  logic row_hit;
  logic kind_exist;
  logic need_alone;
  logic fin_more;
  logic row_store;

  assign {slot_rhash, slot_rhead}        = slot_rdata;
  assign {row_rkey, row_rkv, row_rnext} = row_rdata;

  assign is_insert  = (cmd_q == CMD_INSERT);
  assign slot_miss  = !used_q[slot_q] || (probes_q == SlotCnt);
  assign slot_hit   = (slot_rhash == hash_val);
  assign chain_end  = (br_q >= RowEnd) || (br_q >= count_q);
  assign row_hit    = row_rkv && (row_rkey == key_q);
  assign kind_exist = (kind_q == JK_SEMI) || (kind_q == JK_ANTI);
  assign need_alone = ((kind_q == JK_SEMI) && found_q) ||
                      ((kind_q == JK_ANTI) && !found_q) ||
                      (((kind_q == JK_LEFT) || (kind_q == JK_FULL)) && !found_q);
  assign fin_more   = (fin_q < count_q);
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE);

  hj_hash_unit #(
    .SLOTS(SLOTS)
  ) u_hash (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(hash_start),
    .key_i  (key_i),
    .null_i (!key_valid_i),
    .done_o (hash_done),
    .hash_o (hash_val),
    .slot_o (hash_slot)
  );

  hj_ram #(
    .WIDTH(SlotW),
    .DEPTH(SLOTS)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (slot_we),
    .waddr_i(slot_q),
    .wdata_i(slot_wdata),
    .re_i   (slot_re),
    .raddr_i(slot_q),
    .rdata_o(slot_rdata)
  );

  hj_ram #(
    .WIDTH(RowW),
    .DEPTH(BUILD_ROWS)
  ) u_row_ram (
    .clk_i  (clk_i),
    .we_i   (row_we),
    .waddr_i(count_q[IW-1:0]),
    .wdata_i(row_wdata),
    .re_i   (row_re),
    .raddr_i(br_q[IW-1:0]),
    .rdata_o(row_rdata)
  );

  // result produced this cycle, and the end-of-command flush
  always_comb begin
    prod      = 1'b0;
    prod_kind = RK_PAIR;
    prod_tag  = '0;
    prod_idx  = '0;
    prod_err  = ERR_OK;
    flush_req = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && (cmd_e'(cmd_i) == CMD_INSERT)) begin
          if (phase_q != PH_BUILD) begin
            prod      = 1'b1;
            prod_kind = RK_REJECT;
            prod_err  = ERR_LATE;
          end else if (count_q >= RowEnd) begin
            prod      = 1'b1;
            prod_kind = RK_REJECT;
            prod_err  = ERR_FULL;
          end
        end
      end
      ST_WALK_CMP: begin
        if (row_hit && !kind_exist) begin
          prod      = 1'b1;
          prod_kind = RK_PAIR;
          prod_tag  = tag_q;
          prod_idx  = 6'(br_q);
        end
      end
      ST_DECIDE: begin
        if (need_alone) begin
          prod      = 1'b1;
          prod_kind = RK_PROBE;
          prod_tag  = tag_q;
        end
      end
      ST_FIN: begin
        if (fin_more && !matched_q[fin_q[IW-1:0]]) begin
          prod      = 1'b1;
          prod_kind = RK_BUILD;
          prod_idx  = 6'(fin_q);
        end
      end
      ST_FLUSH: begin
        flush_req = pend_valid_q;
      end
      default: ;
    endcase
  end

  assign stall = pend_valid_q && !out_free && (prod || flush_req);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (cmd_e'(cmd_i))
            CMD_INSERT: state_d = prod ? ST_FLUSH : ST_HASH;
            CMD_PROBE:  state_d = key_valid_i ? ST_HASH : ST_DECIDE;
            CMD_FINAL: begin
              if ((join_kind_q == JK_FULL) && (phase_q != PH_FINAL)) begin
                state_d = ST_FIN;
              end
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_HASH: begin
        if (hash_done) begin
          state_d = ST_SLOT_RD;
        end
      end
      ST_SLOT_RD: begin
        if (slot_miss) begin
          state_d = is_insert ? ST_IDLE : ST_DECIDE;
        end else begin
          state_d = ST_SLOT_CMP;
        end
      end
      ST_SLOT_CMP: begin
        if (slot_hit) begin
          state_d = is_insert ? ST_IDLE : ST_WALK_RD;
        end else begin
          state_d = ST_SLOT_RD;
        end
      end
      ST_WALK_RD: begin
        state_d = chain_end ? ST_DECIDE : ST_WALK_CMP;
      end
      ST_WALK_CMP: begin
        if (row_hit && kind_exist) begin
          state_d = ST_DECIDE;
        end else if (!stall) begin
          state_d = ST_WALK_RD;
        end
      end
      ST_DECIDE: begin
        if (!stall) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FIN: begin
        if (!fin_more) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!stall) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    join_kind_d  = cfg_we_i ? cfg_wdata_i : join_kind_q;
    phase_d      = phase_q;
    count_d      = count_q;
    used_d       = used_q;
    matched_d    = matched_q;
    cmd_d        = cmd_q;
    key_d        = key_q;
    kv_d         = kv_q;
    tag_d        = tag_q;
    kind_d       = kind_q;
    slot_d       = slot_q;
    probes_d     = probes_q;
    br_d         = br_q;
    fin_d        = fin_q;
    found_d      = found_q;
    pend_valid_d = pend_valid_q;
    pend_kind_d  = pend_kind_q;
    pend_tag_d   = pend_tag_q;
    pend_idx_d   = pend_idx_q;
    pend_err_d   = pend_err_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_kind_d   = out_kind_q;
    out_tag_d    = out_tag_q;
    out_idx_d    = out_idx_q;
    out_err_d    = out_err_q;
    out_last_d   = out_last_q;
    hash_start   = 1'b0;
    slot_we      = 1'b0;
    slot_re      = 1'b0;
    slot_wdata   = {hash_val, count_q[IW-1:0]};
    row_store    = 1'b0;
    row_re       = 1'b0;
    row_wdata    = {key_q, kv_q, RowEnd};

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_d   = cmd_e'(cmd_i);
          key_d   = key_i;
          kv_d    = key_valid_i;
          tag_d   = probe_tag_i & TagMask;
          kind_d  = (join_kind_q > JK_ANTI) ? JK_INNER : join_kind_q;
          found_d = 1'b0;
          fin_d   = '0;
          case (cmd_e'(cmd_i))
            CMD_INSERT: hash_start = !prod;
            CMD_PROBE: begin
              hash_start = key_valid_i;
              if (phase_q == PH_BUILD) begin
                phase_d = PH_PROBE;
              end
            end
            CMD_FINAL: phase_d = PH_FINAL;
            default: ;
          endcase
        end
      end
      ST_HASH: begin
        slot_d   = hash_slot;
        probes_d = '0;
      end
      ST_SLOT_RD: begin
        if (slot_miss) begin
          if (is_insert) begin
            row_store = 1'b1;
            if (!used_q[slot_q]) begin
              slot_we        = 1'b1;
              used_d[slot_q] = 1'b1;
            end
          end
        end else begin
          slot_re = 1'b1;
        end
      end
      ST_SLOT_CMP: begin
        if (slot_hit) begin
          if (is_insert) begin
            // new row becomes the chain head
            row_store = 1'b1;
            row_wdata = {key_q, kv_q, CW'(slot_rhead)};
            slot_we   = 1'b1;
          end else begin
            br_d = CW'(slot_rhead);
          end
        end else begin
          slot_d   = (slot_q == SlotTop) ? '0 : slot_q + 1'b1;
          probes_d = probes_q + 1'b1;
        end
      end
      ST_WALK_RD: begin
        row_re = !chain_end;
      end
      ST_WALK_CMP: begin
        if (row_hit) begin
          found_d = 1'b1;
        end
        if (!(row_hit && kind_exist) && !stall) begin
          br_d = row_rnext;
          if (row_hit && (kind_q == JK_FULL)) begin
            matched_d[br_q[IW-1:0]] = 1'b1;
          end
        end
      end
      ST_FIN: begin
        if (fin_more && !stall) begin
          fin_d = fin_q + 1'b1;
        end
      end
      default: ;
    endcase

    row_we = row_store;
    if (row_store) begin
      count_d                      = count_q + 1'b1;
      matched_d[count_q[IW-1:0]] = 1'b0;
    end

    // hold stage feeds the output register; last is known once the next
    // item or the end of the command shows up
    if (prod && !stall) begin
      if (pend_valid_q) begin
        out_valid_d = 1'b1;
        out_kind_d  = pend_kind_q;
        out_tag_d   = pend_tag_q;
        out_idx_d   = pend_idx_q;
        out_err_d   = pend_err_q;
        out_last_d  = 1'b0;
      end
      pend_valid_d = 1'b1;
      pend_kind_d  = prod_kind;
      pend_tag_d   = prod_tag;
      pend_idx_d   = prod_idx;
      pend_err_d   = prod_err;
    end
    if (flush_req && !stall) begin
      out_valid_d  = 1'b1;
      out_kind_d   = pend_kind_q;
      out_tag_d    = pend_tag_q;
      out_idx_d    = pend_idx_q;
      out_err_d    = pend_err_q;
      out_last_d   = 1'b1;
      pend_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      join_kind_q  <= JK_INNER;
      phase_q      <= PH_BUILD;
      count_q      <= '0;
      used_q       <= '0;
      matched_q    <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      join_kind_q  <= join_kind_d;
      phase_q      <= phase_d;
      count_q      <= count_d;
      used_q       <= used_d;
      matched_q    <= matched_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    key_q       <= key_d;
    kv_q        <= kv_d;
    tag_q       <= tag_d;
    kind_q      <= kind_d;
    slot_q      <= slot_d;
    probes_q    <= probes_d;
    br_q        <= br_d;
    fin_q       <= fin_d;
    found_q     <= found_d;
    pend_kind_q <= pend_kind_d;
    pend_tag_q  <= pend_tag_d;
    pend_idx_q  <= pend_idx_d;
    pend_err_q  <= pend_err_d;
    out_kind_q  <= out_kind_d;
    out_tag_q   <= out_tag_d;
    out_idx_q   <= out_idx_d;
    out_err_q   <= out_err_d;
    out_last_q  <= out_last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign row_kind_o    = out_kind_q;
  assign out_tag_o     = out_tag_q;
  assign build_index_o = out_idx_q;
  assign error_code_o  = out_err_q;
  assign last_o        = out_last_q;

  `HJ_ASSERT_NOW(a_idle_no_pend, state_q == ST_IDLE, !pend_valid_q, "item held while idle")
  `HJ_ASSERT_NEXT(a_count_step, row_store, count_q == $past(count_q) + 1'b1, "row count slip")
  `HJ_ASSERT_NEXT(a_phase_keep, phase_q != PH_BUILD, phase_q != PH_BUILD, "phase fell back")
  `HJ_ASSERT_NOW(a_count_max, 1'b1, count_q <= RowEnd, "row count overflow")

endmodule

### verif/hash_join_int64_key_core_tb.sv
// ----------------------------------------------------------------------------
// hash_join_int64_key_core_tb
// Drives build, probe and finalize items through the hash join core, probes
// under every join kind, predicts the result items with its own hash table
// model and compares each result field by field, in order.
// ----------------------------------------------------------------------------
module hash_join_int64_key_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hj_pkg::*;

  localparam int unsigned NROWS     = 64;
  localparam int unsigned NSLOTS    = 128;
  localparam int unsigned IDLE_WAIT = 200;
  localparam int unsigned WDOG_MAX  = 20000;

  typedef struct packed {
    logic [1:0]  row_kind;
    logic [31:0] out_tag;
    logic [5:0]  build_index;
    logic [1:0]  error_code;
    logic        last;
  } join_row_t;

  class join_scoreboard;
    logic [2:0]  join_kind;
    bit          slot_used [NSLOTS];
    logic [5:0]  slot_head [NSLOTS];
    logic [63:0] slot_sig [NSLOTS];
    logic [6:0]  chain_next [NROWS];
    logic [63:0] row_key [NROWS];
    bit          row_key_valid [NROWS];
    bit          row_matched [NROWS];
    int unsigned build_count;
    logic [1:0]  phase;
    join_row_t   pending [$];
    int unsigned errors;

    function void clear();
      join_kind = JK_INNER;
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      foreach (row_matched[i]) row_matched[i] = 1'b0;
      build_count = 0;
      phase = PH_BUILD;
      pending.delete();
      errors = 0;
    endfunction

    function logic [63:0] fnv_hash(logic [63:0] key, bit valid);
      logic [63:0] h;
      h = FnvBasis;
      if (!valid) return FnvBasis ^ NullMix;
      for (int i = 0; i < 8; i++) begin
        h = h ^ {56'd0, key[8*i +: 8]};
        h = h * 64'd1099511628211;
      end
      return h;
    endfunction

    function void push(logic [1:0] kind, logic [31:0] tag, logic [5:0] idx,
                       logic [1:0] err);
      join_row_t r;
      r.row_kind = kind;
      r.out_tag = tag;
      r.build_index = idx;
      r.error_code = err;
      r.last = 1'b0;
      pending.push_back(r);
    endfunction

    function void note_item(logic [1:0] cmd, logic [63:0] key, bit kv, logic [31:0] tag);
      int unsigned n0, steps;
      logic [6:0] s;
      logic [6:0] br;
      bit hit;
      bit found;
      logic [63:0] h;
      logic [2:0] kind;
      n0 = pending.size();
      kind = (join_kind > JK_ANTI) ? JK_INNER : join_kind;
      case (cmd)
        CMD_INSERT: begin
          if (phase != PH_BUILD) push(RK_REJECT, '0, '0, ERR_LATE);
          else if (build_count >= NROWS) push(RK_REJECT, '0, '0, ERR_FULL);
          else begin
            br = 7'(build_count);
            row_key[br[5:0]] = key;
            row_key_valid[br[5:0]] = kv;
            row_matched[br[5:0]] = 1'b0;
            chain_next[br[5:0]] = 7'(NROWS);
            h = fnv_hash(key, kv);
            s = h[6:0];
            for (int i = 0; i < NSLOTS; i++) begin
              if (!slot_used[s]) begin
                slot_used[s] = 1'b1;
                slot_sig[s] = h;
                slot_head[s] = br[5:0];
                break;
              end
              if (slot_sig[s] == h) begin
                chain_next[br[5:0]] = {1'b0, slot_head[s]};
                slot_head[s] = br[5:0];
                break;
              end
              s = s + 7'd1;
            end
            build_count = build_count + 1;
          end
        end
        CMD_PROBE: begin
          found = 1'b0;
          hit = 1'b0;
          s = '0;
          if (phase == PH_BUILD) phase = PH_PROBE;
          if (kv) begin
            h = fnv_hash(key, 1'b1);
            s = h[6:0];
            for (int i = 0; i < NSLOTS; i++) begin
              if (!slot_used[s]) break;
              if (slot_sig[s] == h) begin
                hit = 1'b1;
                break;
              end
              s = s + 7'd1;
            end
          end
          if (hit) begin
            br = {1'b0, slot_head[s]};
            steps = 0;
            while (steps < NROWS && br < 7'(NROWS) && 32'(br) < build_count) begin
              if (row_key_valid[br[5:0]] && row_key[br[5:0]] == key) begin
                found = 1'b1;
                if (kind == JK_SEMI || kind == JK_ANTI) break;
                if (kind == JK_FULL) row_matched[br[5:0]] = 1'b1;
                push(RK_PAIR, tag, br[5:0], ERR_OK);
              end
              br = chain_next[br[5:0]];
              steps++;
            end
          end
          if ((kind == JK_SEMI && found) || (kind == JK_ANTI && !found) ||
              ((kind == JK_LEFT || kind == JK_FULL) && !found))
            push(RK_PROBE, tag, '0, ERR_OK);
        end
        CMD_FINAL: begin
          if (phase != PH_FINAL && join_kind == JK_FULL)
            for (int unsigned r = 0; r < build_count; r++)
              if (!row_matched[r[5:0]]) push(RK_BUILD, '0, r[5:0], ERR_OK);
          phase = PH_FINAL;
        end
        default: ;
      endcase
      if (pending.size() > n0) pending[pending.size()-1].last = 1'b1;
    endfunction

    task check_row(join_row_t got);
      join_row_t want;
      if (pending.size() == 0) begin
        report_mismatch("result item with nothing expected", got, got);
        return;
      end
      want = pending.pop_front();
      if (got != want) report_mismatch("result item differs", got, want);
    endtask

    task report_mismatch(string what, join_row_t got, join_row_t want);
      errors++;
      $display({"MISMATCH %s: got kind %0d tag %h idx %0d err %0d last %0b, ",
                "want kind %0d tag %h idx %0d err %0d last %0b"},
               what, got.row_kind, got.out_tag, got.build_index, got.error_code, got.last,
               want.row_kind, want.out_tag, want.build_index, want.error_code, want.last);
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  cmd_i = '0;
  logic [63:0] key_i = '0;
  logic        key_valid_i = 1'b0;
  logic [31:0] probe_tag_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  row_kind_o;
  logic [31:0] out_tag_o;
  logic [5:0]  build_index_o;
  logic [1:0]  error_code_o;
  logic        last_o;

  join_scoreboard sb = new();
  bit          calm = 1'b0;
  int unsigned quiet_cycles = 0;
  logic [63:0] key_pool [8];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  hash_join_int64_key_core u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .cmd_i(cmd_i), .key_i(key_i), .key_valid_i(key_valid_i), .probe_tag_i(probe_tag_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
    .row_kind_o(row_kind_o), .out_tag_o(out_tag_o), .build_index_o(build_index_o),
    .error_code_o(error_code_o), .last_o(last_o)
  );

  // result side: check and stall at random
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i)
        sb.check_row({row_kind_o, out_tag_o, build_index_o, error_code_o, last_o});
      out_ready_i <= calm || ($urandom_range(99) >= 7);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > WDOG_MAX) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // valid stays high into the next item; idle gaps and drain drop it
  task automatic send_item(logic [1:0] cmd, logic [63:0] key, bit kv, logic [31:0] tag);
    while (!calm && $urandom_range(99) < 7) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    cmd_i <= cmd;
    key_i <= key;
    key_valid_i <= kv;
    probe_tag_i <= tag;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_item(cmd, key, kv, tag);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (IDLE_WAIT) @(posedge clk_i);
  endtask

  task automatic set_kind(logic [2:0] kind);
    cfg_wdata_i <= kind;
    cfg_we_i <= 1'b1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.join_kind = kind;
  endtask

  function automatic logic [63:0] pick_key();
    if ($urandom_range(99) < 75) return key_pool[3'($urandom_range(7))];
    return {$urandom, $urandom};
  endfunction

  // reset happens only once, so the core keeps its table; rounds reuse the
  // same build and send only probe and no-op items
  task automatic random_round(int unsigned probes);
    for (int i = 0; i < probes; i++)
      send_item(($urandom_range(19) == 0) ? CMD_NONE : CMD_PROBE, pick_key(),
                $urandom_range(9) != 0, $urandom);
  endtask

  initial begin
    logic [2:0] kinds [8];
    sb.clear();
    foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
    key_pool[0] = 64'd0;
    key_pool[1] = '1;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_kind(JK_FULL);

    // directed build: extremes, duplicates and null keys
    send_item(CMD_INSERT, 64'd0, 1'b1, '0);
    send_item(CMD_INSERT, '1, 1'b1, '1);
    send_item(CMD_INSERT, 64'd0, 1'b1, '0);
    send_item(CMD_INSERT, 64'd0, 1'b0, '0);
    send_item(CMD_INSERT, '1, 1'b0, '0);
    send_item(CMD_NONE, 64'h5555_5555_5555_5555, 1'b1, 32'h5555_5555);
    // long stretch of random build items to reach a full table
    calm = 1'b1;
    while (sb.build_count < NROWS)
      send_item(CMD_INSERT, pick_key(), $urandom_range(9) != 0, $urandom);
    calm = 1'b0;
    send_item(CMD_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 32'hAAAA_AAAA);
    // probes under full join, a null probe, a late insert, finalize twice, then a probe and an insert
    send_item(CMD_PROBE, 64'd0, 1'b1, '1);
    send_item(CMD_PROBE, '1, 1'b1, 32'd0);
    send_item(CMD_PROBE, 64'd0, 1'b0, 32'h1234_5678);
    send_item(CMD_PROBE, 64'h0123_4567_89AB_CDEF, 1'b1, 32'hDEAD_BEEF);
    send_item(CMD_INSERT, 64'd7, 1'b1, '0);
    send_item(CMD_FINAL, '0, 1'b0, '0);
    send_item(CMD_FINAL, '0, 1'b0, '0);
    send_item(CMD_PROBE, 64'd0, 1'b1, 32'h0F0F_0F0F);
    send_item(CMD_INSERT, 64'd7, 1'b1, '0);
    drain();

    // random probes through every kind, undefined kinds among them
    kinds = '{JK_INNER, JK_LEFT, JK_SEMI, JK_ANTI, 3'd5, 3'd7, JK_FULL, 3'd6};
    foreach (kinds[k]) begin
      set_kind(kinds[k]);
      if (k == 2) calm = 1'b1;
      random_round(55);
      calm = 1'b0;
      if (kinds[k] == JK_FULL) send_item(CMD_FINAL, '0, 1'b0, '0);
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

### hash_join_int64_key_core.f
+incdir+hw/rtl
hw/rtl/hj_pkg.sv
hw/rtl/hj_ram.sv
hw/rtl/hj_hash_unit.sv
hw/rtl/hash_join_int64_key_core.sv
verif/hash_join_int64_key_core_tb.sv
